### hw/rtl/side_window_median_filter_defines.svh
// ----------------------------------------------------------------------------
// side window median filter assertion macros
// Concurrent assertion wrappers on clk_i and rst_ni, removed by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SIDE_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define SIDE_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SWMF_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("swmf property violated");
`define SWMF_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("swmf forbidden condition seen");
`else
`define SWMF_ASSERT(name, prop)
`define SWMF_ASSERT_NEVER(name, expr)
`endif
`endif

### hw/rtl/swmf_pkg.sv
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared widths, register codes and request types of the side window filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int RAD_W      = 3;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 10;
  localparam int SLOT_W     = 5;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = 24;
  localparam int SIDE_W     = 3;
  localparam int NUM_SIDES  = 8;
  localparam int LAG_W      = 15;
  localparam int ERR_W      = 10;
  localparam int MAX_HEIGHT = 1024;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd480;
  localparam logic [RAD_W-1:0] RST_RADIUS = 3'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RADIUS = 2'd2
  } cfg_idx_e;

  // effective (clamped) frame geometry
  typedef struct packed {
    logic [COL_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [RAD_W-1:0] radius;
  } cfg_t;

  // one output position to be filtered
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } job_t;

endpackage

### hw/rtl/swmf_line_store.sv
// ----------------------------------------------------------------------------
// swmf_line_store
// Row buffer of source pixels, one write port and one registered read port.
// ----------------------------------------------------------------------------
module swmf_line_store #(
  parameter int Depth = 9216,
  parameter int AddrW = 14
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [swmf_pkg::PIX_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [swmf_pkg::PIX_W-1:0] rd_data_o
);

  logic [swmf_pkg::PIX_W-1:0] mem [Depth];
  logic [swmf_pkg::PIX_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hw/rtl/swmf_job_queue.sv
// ----------------------------------------------------------------------------
// swmf_job_queue
// Two entry queue of output positions between the front and the back end.
// ----------------------------------------------------------------------------
`include "side_window_median_filter_defines.svh"

module swmf_job_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  swmf_pkg::job_t  job_i,
  input  logic            pop_i,
  output swmf_pkg::job_t  job_o,
  output logic            empty_o,
  output logic            full_o
);

  swmf_pkg::job_t entry_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign job_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        entry_q[wr_ptr_q] <= job_i;
        wr_ptr_q          <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  `SWMF_ASSERT_NEVER(a_queue_overflow, push_i && full_o && !pop_i)
  `SWMF_ASSERT_NEVER(a_queue_underflow, pop_i && empty_o)

endmodule

### hw/rtl/swmf_front.sv
// ----------------------------------------------------------------------------
// swmf_front
// Configuration, frame position tracking, line store writes and request
// classification into output positions.
// ----------------------------------------------------------------------------
`include "side_window_median_filter_defines.svh"

module swmf_front #(
  parameter int MaxWidth  = 1024,
  parameter int MaxRadius = 4,
  parameter int AddrW     = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swmf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [swmf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [swmf_pkg::PIX_W-1:0]     pixel_bgr_i,
  input  logic                           idle_i,
  output swmf_pkg::cfg_t                 cfg_o,
  output logic                           wr_en_o,
  output logic [AddrW-1:0]               wr_addr_o,
  output logic [swmf_pkg::PIX_W-1:0]     wr_data_o,
  output logic                           job_valid_o,
  output swmf_pkg::job_t                 job_o
);

  localparam int StoreRows = 2 * MaxRadius + 1;

  logic [swmf_pkg::CFG_W-1:0]  width_q;
  logic [swmf_pkg::CFG_W-1:0]  height_q;
  logic [swmf_pkg::RAD_W-1:0]  radius_q;

  logic [swmf_pkg::COL_W-1:0]  in_x_q;
  logic [swmf_pkg::ROW_W-1:0]  in_y_q;
  logic [swmf_pkg::SLOT_W-1:0] in_slot_q;
  logic                        in_done_q;
  logic [swmf_pkg::COL_W-1:0]  out_x_q;
  logic [swmf_pkg::ROW_W-1:0]  out_y_q;
  logic [swmf_pkg::SLOT_W-1:0] out_slot_q;
  logic [swmf_pkg::LAG_W-1:0]  pend_q;

  logic [swmf_pkg::RAD_W-1:0]  r;
  logic [swmf_pkg::COL_W-1:0]  w;
  logic [swmf_pkg::CFG_W-1:0]  h;
  logic [swmf_pkg::COL_W-1:0]  w_m1;
  logic [swmf_pkg::CFG_W-1:0]  h_m1;
  logic [swmf_pkg::LAG_W-1:0]  lag;
  logic [swmf_pkg::LAG_W-1:0]  pend_inc;
  logic                        fire;
  logic                        is_pix;
  logic                        in_last;
  logic                        out_last;
  logic                        emit;
  logic                        cfg_hit;

  // clamped geometry
  always_comb begin
    if (radius_q == '0) begin
      r = swmf_pkg::RAD_W'(1);
    end else if (int'(radius_q) > MaxRadius) begin
      r = swmf_pkg::RAD_W'(MaxRadius);
    end else begin
      r = radius_q;
    end
    if (width_q < swmf_pkg::COL_W'(r) + swmf_pkg::COL_W'(1)) begin
      w = swmf_pkg::COL_W'(r) + swmf_pkg::COL_W'(1);
    end else if (int'(width_q) > MaxWidth) begin
      w = swmf_pkg::COL_W'(MaxWidth);
    end else begin
      w = width_q;
    end
    if (height_q < swmf_pkg::CFG_W'(r) + swmf_pkg::CFG_W'(1)) begin
      h = swmf_pkg::CFG_W'(r) + swmf_pkg::CFG_W'(1);
    end else if (int'(height_q) > swmf_pkg::MAX_HEIGHT) begin
      h = swmf_pkg::CFG_W'(swmf_pkg::MAX_HEIGHT);
    end else begin
      h = height_q;
    end
  end

  assign w_m1 = w - swmf_pkg::COL_W'(1);
  assign h_m1 = h - swmf_pkg::CFG_W'(1);
  assign lag  = swmf_pkg::LAG_W'(r) * swmf_pkg::LAG_W'(w) + swmf_pkg::LAG_W'(r);

  assign cfg_o.width  = w;
  assign cfg_o.height = h;
  assign cfg_o.radius = r;

  assign in_ready_o = idle_i;
  assign fire       = in_valid_i && in_ready_o;
  assign is_pix     = fire && !cmd_i && !in_done_q;
  assign pend_inc   = pend_q + swmf_pkg::LAG_W'(1);
  assign in_last    = (in_x_q == w_m1) && (swmf_pkg::CFG_W'(in_y_q) == h_m1);
  assign out_last   = (out_x_q == w_m1) && (swmf_pkg::CFG_W'(out_y_q) == h_m1);
  assign emit       = is_pix ? ((pend_inc > lag) || in_last) : (fire && in_done_q);
  assign cfg_hit    = cfg_we_i && (cfg_idx_i == swmf_pkg::CFG_WIDTH
                      || cfg_idx_i == swmf_pkg::CFG_HEIGHT
                      || cfg_idx_i == swmf_pkg::CFG_RADIUS);

  assign wr_en_o   = is_pix;
  assign wr_addr_o = AddrW'(in_slot_q) * AddrW'(MaxWidth) + AddrW'(in_x_q);
  assign wr_data_o = pixel_bgr_i;

  assign job_valid_o = emit;
  assign job_o.row   = out_y_q;
  assign job_o.col   = out_x_q;
  assign job_o.slot  = out_slot_q;
  assign job_o.last  = out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= swmf_pkg::RST_WIDTH;
      height_q   <= swmf_pkg::RST_HEIGHT;
      radius_q   <= swmf_pkg::RST_RADIUS;
      in_x_q     <= '0;
      in_y_q     <= '0;
      in_slot_q  <= '0;
      in_done_q  <= 1'b0;
      out_x_q    <= '0;
      out_y_q    <= '0;
      out_slot_q <= '0;
      pend_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        swmf_pkg::CFG_WIDTH:  width_q  <= cfg_wdata_i;
        swmf_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i;
        swmf_pkg::CFG_RADIUS: radius_q <= cfg_wdata_i[swmf_pkg::RAD_W-1:0];
        default: ;
      endcase
      if (cfg_hit) begin
        in_x_q     <= '0;
        in_y_q     <= '0;
        in_slot_q  <= '0;
        in_done_q  <= 1'b0;
        out_x_q    <= '0;
        out_y_q    <= '0;
        out_slot_q <= '0;
        pend_q     <= '0;
      end
    end else begin
      if (is_pix) begin
        if (in_last) begin
          in_done_q <= 1'b1;
          in_x_q    <= '0;
          in_y_q    <= '0;
          in_slot_q <= '0;
        end else if (in_x_q == w_m1) begin
          in_x_q    <= '0;
          in_y_q    <= in_y_q + swmf_pkg::ROW_W'(1);
          in_slot_q <= (int'(in_slot_q) == StoreRows - 1) ? '0
                       : in_slot_q + swmf_pkg::SLOT_W'(1);
        end else begin
          in_x_q <= in_x_q + swmf_pkg::COL_W'(1);
        end
      end
      if (is_pix && !emit) begin
        pend_q <= pend_inc;
      end else if (emit && !is_pix) begin
        pend_q <= pend_q - swmf_pkg::LAG_W'(1);
      end
      if (emit) begin
        if (out_x_q == w_m1) begin
          out_x_q    <= '0;
          out_y_q    <= out_y_q + swmf_pkg::ROW_W'(1);
          out_slot_q <= (int'(out_slot_q) == StoreRows - 1) ? '0
                        : out_slot_q + swmf_pkg::SLOT_W'(1);
        end else begin
          out_x_q <= out_x_q + swmf_pkg::COL_W'(1);
        end
        if (out_last) begin
          in_x_q     <= '0;
          in_y_q     <= '0;
          in_slot_q  <= '0;
          in_done_q  <= 1'b0;
          out_x_q    <= '0;
          out_y_q    <= '0;
          out_slot_q <= '0;
          pend_q     <= '0;
        end
      end
    end
  end

  `SWMF_ASSERT(a_pend_within_lag, pend_q <= lag)

endmodule

### hw/rtl/swmf_back.sv
// ----------------------------------------------------------------------------
// swmf_back
// Per output position: bitwise median search over the eight side windows,
// reading the neighborhood from the line store once per result bit, then
// least L1 error selection into the output register.
// ----------------------------------------------------------------------------
`include "side_window_median_filter_defines.svh"

module swmf_back #(
  parameter int MaxWidth  = 1024,
  parameter int MaxRadius = 4,
  parameter int AddrW     = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swmf_pkg::cfg_t              cfg_i,
  input  logic                        job_valid_i,
  input  swmf_pkg::job_t              job_i,
  output logic                        job_pop_o,
  output logic                        idle_o,
  output logic                        rd_en_o,
  output logic [AddrW-1:0]            rd_addr_o,
  input  logic [swmf_pkg::PIX_W-1:0]  rd_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [swmf_pkg::PIX_W-1:0]  out_bgr_o,
  output logic [swmf_pkg::SIDE_W-1:0] chosen_side_o,
  output logic                        frame_last_o
);

  localparam int StoreRows = 2 * MaxRadius + 1;
  localparam int MaxWin    = (MaxRadius + 1) * (2 * MaxRadius + 1);
  localparam int CntW      = $clog2(MaxWin + 1);
  localparam int OffW      = swmf_pkg::RAD_W + 1;
  localparam int PosW      = 13;
  localparam int SlotSW    = 7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_STEP, ST_ERR, ST_PICK
  } state_e;

  typedef enum logic [2:0] {
    SIDE_L, SIDE_R, SIDE_U, SIDE_D, SIDE_LU, SIDE_LD, SIDE_RU, SIDE_RD
  } side_e;

  state_e                           state_q;
  swmf_pkg::job_t                   job_q;
  logic signed [OffW-1:0]           dy_q;
  logic signed [OffW-1:0]           dx_q;
  logic [2:0]                       bit_q;
  logic [swmf_pkg::CH_W-1:0]        med_q [swmf_pkg::NUM_SIDES][swmf_pkg::NUM_CH];
  logic [CntW-1:0]                  cnt_q [swmf_pkg::NUM_SIDES][swmf_pkg::NUM_CH];
  logic                             tag_v_q;
  logic signed [OffW-1:0]           tag_dy_q;
  logic signed [OffW-1:0]           tag_dx_q;
  logic [swmf_pkg::PIX_W-1:0]       src_q;
  logic [swmf_pkg::ERR_W-1:0]       err_q [swmf_pkg::NUM_SIDES];
  logic                             out_valid_q;
  logic [swmf_pkg::PIX_W-1:0]       out_bgr_q;
  logic [swmf_pkg::SIDE_W-1:0]      side_q;
  logic                             last_q;

  logic signed [OffW-1:0]           r_s;
  logic signed [OffW-1:0]           r_neg;
  logic signed [PosW-1:0]           row_s;
  logic signed [PosW-1:0]           ri;
  logic signed [PosW-1:0]           ci;
  logic signed [PosW-1:0]           re;
  logic signed [SlotSW-1:0]         sl;
  logic [swmf_pkg::CH_W-1:0]        low_mask;
  logic [CntW-1:0]                  k_half;
  logic [CntW-1:0]                  k_quad;
  logic                             inc [swmf_pkg::NUM_SIDES][swmf_pkg::NUM_CH];
  logic [swmf_pkg::ERR_W-1:0]       err_c [swmf_pkg::NUM_SIDES];
  logic [swmf_pkg::SIDE_W-1:0]      best_side;
  logic [swmf_pkg::ERR_W-1:0]       best_err;
  logic                             out_free;

  function automatic logic signed [PosW-1:0] reflect(input logic signed [PosW-1:0] i,
                                                     input logic signed [PosW-1:0] last);
    logic signed [PosW-1:0] v;
    v = i;
    if (v < 0) begin
      v = -v;
    end
    if (v > last) begin
      v = (last <<< 1) - v;
    end
    return v;
  endfunction

  function automatic logic in_side(input side_e s, input logic signed [OffW-1:0] dy,
                                   input logic signed [OffW-1:0] dx);
    logic m;
    unique case (s)
      SIDE_L:  m = (dx <= 0);
      SIDE_R:  m = (dx >= 0);
      SIDE_U:  m = (dy <= 0);
      SIDE_D:  m = (dy >= 0);
      SIDE_LU: m = (dx <= 0) && (dy <= 0);
      SIDE_LD: m = (dx <= 0) && (dy >= 0);
      SIDE_RU: m = (dx >= 0) && (dy <= 0);
      SIDE_RD: m = (dx >= 0) && (dy >= 0);
      default: m = 1'b0;
    endcase
    return m;
  endfunction

  assign r_s   = $signed({1'b0, cfg_i.radius});
  assign r_neg = -r_s;

  // neighborhood address with reflect-101 borders
  always_comb begin
    row_s = $signed({3'b000, job_q.row});
    ri    = reflect(row_s + PosW'(dy_q), $signed({2'b00, cfg_i.height}) - PosW'(1));
    ci    = reflect($signed({2'b00, job_q.col}) + PosW'(dx_q),
                    $signed({2'b00, cfg_i.width}) - PosW'(1));
    re    = ri - row_s;
    sl    = $signed({2'b00, job_q.slot}) + SlotSW'(re);
    if (sl < 0) begin
      sl = sl + SlotSW'(StoreRows);
    end else if (sl >= SlotSW'(StoreRows)) begin
      sl = sl - SlotSW'(StoreRows);
    end
  end

  assign rd_en_o   = (state_q == ST_SCAN);
  assign rd_addr_o = AddrW'($unsigned(sl)) * AddrW'(MaxWidth) + AddrW'($unsigned(ci));

  assign low_mask = (swmf_pkg::CH_W'(1) << bit_q) - swmf_pkg::CH_W'(1);
  assign k_half   = CntW'(((CntW'(cfg_i.radius) + CntW'(1))
                           * (CntW'(cfg_i.radius) * CntW'(2) + CntW'(1))) >> 1);
  assign k_quad   = CntW'(((CntW'(cfg_i.radius) + CntW'(1))
                           * (CntW'(cfg_i.radius) + CntW'(1))) >> 1);

  always_comb begin
    for (int s = 0; s < swmf_pkg::NUM_SIDES; s++) begin
      for (int c = 0; c < swmf_pkg::NUM_CH; c++) begin
        inc[s][c] = tag_v_q && in_side(side_e'(s), tag_dy_q, tag_dx_q)
                    && (rd_data_i[c*swmf_pkg::CH_W +: swmf_pkg::CH_W]
                        <= (med_q[s][c] | low_mask));
      end
    end
  end

  always_comb begin
    logic [swmf_pkg::CH_W-1:0] a;
    logic [swmf_pkg::CH_W-1:0] b;
    for (int s = 0; s < swmf_pkg::NUM_SIDES; s++) begin
      err_c[s] = '0;
      for (int c = 0; c < swmf_pkg::NUM_CH; c++) begin
        a = src_q[c*swmf_pkg::CH_W +: swmf_pkg::CH_W];
        b = med_q[s][c];
        err_c[s] = err_c[s] + swmf_pkg::ERR_W'((a > b) ? a - b : b - a);
      end
    end
  end

  // first minimum wins
  always_comb begin
    best_side = '0;
    best_err  = err_q[0];
    for (int s = 1; s < swmf_pkg::NUM_SIDES; s++) begin
      if (err_q[s] < best_err) begin
        best_err  = err_q[s];
        best_side = swmf_pkg::SIDE_W'(s);
      end
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign idle_o    = (state_q == ST_IDLE);
  assign job_pop_o = (state_q == ST_IDLE) && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tag_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      tag_v_q  <= (state_q == ST_SCAN);
      tag_dy_q <= dy_q;
      tag_dx_q <= dx_q;
      if (tag_v_q) begin
        for (int s = 0; s < swmf_pkg::NUM_SIDES; s++) begin
          for (int c = 0; c < swmf_pkg::NUM_CH; c++) begin
            if (inc[s][c]) begin
              cnt_q[s][c] <= cnt_q[s][c] + CntW'(1);
            end
          end
        end
        if (tag_dy_q == 0 && tag_dx_q == 0) begin
          src_q <= rd_data_i;
        end
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            job_q <= job_i;
            dy_q  <= r_neg;
            dx_q  <= r_neg;
            bit_q <= 3'd7;
            for (int s = 0; s < swmf_pkg::NUM_SIDES; s++) begin
              for (int c = 0; c < swmf_pkg::NUM_CH; c++) begin
                med_q[s][c] <= '0;
                cnt_q[s][c] <= '0;
              end
            end
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (dx_q == r_s) begin
            dx_q <= r_neg;
            if (dy_q == r_s) begin
              state_q <= ST_DRAIN;
            end else begin
              dy_q <= dy_q + OffW'(1);
            end
          end else begin
            dx_q <= dx_q + OffW'(1);
          end
        end
        ST_DRAIN: begin
          state_q <= ST_STEP;
        end
        ST_STEP: begin
          for (int s = 0; s < swmf_pkg::NUM_SIDES; s++) begin
            for (int c = 0; c < swmf_pkg::NUM_CH; c++) begin
              if (cnt_q[s][c] < ((s < 4) ? k_half : k_quad)) begin
                med_q[s][c][bit_q] <= 1'b1;
              end
              cnt_q[s][c] <= '0;
            end
          end
          if (bit_q == 3'd0) begin
            state_q <= ST_ERR;
          end else begin
            bit_q   <= bit_q - 3'd1;
            dy_q    <= r_neg;
            dx_q    <= r_neg;
            state_q <= ST_SCAN;
          end
        end
        ST_ERR: begin
          for (int s = 0; s < swmf_pkg::NUM_SIDES; s++) begin
            err_q[s] <= err_c[s];
          end
          state_q <= ST_PICK;
        end
        ST_PICK: begin
          if (out_free) begin
            out_bgr_q   <= {med_q[best_side][2], med_q[best_side][1], med_q[best_side][0]};
            side_q      <= best_side;
            last_q      <= job_q.last;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_bgr_o     = out_bgr_q;
  assign chosen_side_o = side_q;
  assign frame_last_o  = last_q;

  `SWMF_ASSERT(a_drain_sees_last_read, state_q == ST_DRAIN |-> tag_v_q)
  `SWMF_ASSERT(a_step_counts_settled, state_q == ST_STEP |-> !tag_v_q)

endmodule

### hw/rtl/side_window_median_filter.sv
// ----------------------------------------------------------------------------
// side_window_median_filter
// Streams a BGR888 frame in raster order and returns, per pixel, the one of
// eight side window medians (L, R, U, D, LU, LD, RU, RD) closest to the source
// pixel in L1 distance, with reflect-101 borders. The first r*W+r pixel
// requests of a frame give no result; after the last pixel, drain requests
// flush the remaining outputs. For each result the back end reads the
// (2r+1)x(2r+1) neighborhood once per result bit from the single read port of
// the line store. A request is taken only while no earlier position is still
// in the back end; a finished result waits in the output register without
// holding off the next request. The line store holds 2*MAX_RADIUS+1 rows of
// MAX_WIDTH pixels, needs no clearing after reset, and configuration writes
// restart the frame.
// ----------------------------------------------------------------------------
module side_window_median_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [swmf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [swmf_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           cmd_i,
  input  logic [swmf_pkg::PIX_W-1:0]     pixel_bgr_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [swmf_pkg::PIX_W-1:0]     out_bgr_o,
  output logic [swmf_pkg::SIDE_W-1:0]    chosen_side_o,
  output logic                           frame_last_o
);

  localparam int Depth = (2 * MAX_RADIUS + 1) * MAX_WIDTH;
  localparam int AddrW = $clog2(Depth);

  swmf_pkg::cfg_t             cfg;
  logic                       wr_en;
  logic [AddrW-1:0]           wr_addr;
  logic [swmf_pkg::PIX_W-1:0] wr_data;
  logic                       rd_en;
  logic [AddrW-1:0]           rd_addr;
  logic [swmf_pkg::PIX_W-1:0] rd_data;
  logic                       push;
  swmf_pkg::job_t             push_job;
  logic                       pop;
  swmf_pkg::job_t             head_job;
  logic                       q_empty;
  logic                       q_full;
  logic                       back_idle;
  logic                       front_idle;

  assign front_idle = q_empty && !q_full && back_idle;

  swmf_front #(
    .MaxWidth  (MAX_WIDTH),
    .MaxRadius (MAX_RADIUS),
    .AddrW     (AddrW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .pixel_bgr_i (pixel_bgr_i),
    .idle_i      (front_idle),
    .cfg_o       (cfg),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .job_valid_o (push),
    .job_o       (push_job)
  );

  swmf_job_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  swmf_line_store #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  swmf_back #(
    .MaxWidth  (MAX_WIDTH),
    .MaxRadius (MAX_RADIUS),
    .AddrW     (AddrW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .job_valid_i   (!q_empty),
    .job_i         (head_job),
    .job_pop_o     (pop),
    .idle_o        (back_idle),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_bgr_o     (out_bgr_o),
    .chosen_side_o (chosen_side_o),
    .frame_last_o  (frame_last_o)
  );

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// side window median filter testbench
// Drives pixel and drain requests through the valid/ready input, predicts
// each filtered pixel from a local line store and geometry copy, and checks
// every output request against the oldest prediction. Directed frames cover
// pixel extremes, drains, clamped registers and abandoned frames; random
// frames of many sizes and radii follow, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_ROWS = 9;
  localparam int STORE_COLS = 1024;
  localparam int SETTLE_CYC = 800;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int TARGET_REQS = 1650;
  localparam bit CMD_PIXEL = 1'b0;
  localparam bit CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic [swmf_pkg::PIX_W-1:0]  bgr;
    logic [swmf_pkg::SIDE_W-1:0] side;
    logic                        last;
  } filt_pix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [swmf_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [swmf_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = 1'b0;
  logic [swmf_pkg::PIX_W-1:0] pixel_bgr_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [swmf_pkg::PIX_W-1:0] out_bgr_o;
  logic [swmf_pkg::SIDE_W-1:0] chosen_side_o;
  logic frame_last_o;

  side_window_median_filter DUT (.*);

  // predictor state
  logic [swmf_pkg::PIX_W-1:0] line_mem [STORE_ROWS][STORE_COLS];
  logic [swmf_pkg::CFG_W-1:0] width_reg = swmf_pkg::RST_WIDTH;
  logic [swmf_pkg::CFG_W-1:0] height_reg = swmf_pkg::RST_HEIGHT;
  logic [swmf_pkg::RAD_W-1:0] radius_reg = swmf_pkg::RST_RADIUS;
  int unsigned pix_in_cnt = 0;
  int unsigned pix_out_cnt = 0;
  filt_pix_t pending_pix [$];

  int n_reqs = 0;
  int n_errors = 0;
  int unsigned cycle_cnt = 0;
  bit idle_en = 1'b1;
  bit hold_req = 1'b0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver with random stalls and one long hold-off on request
  initial begin
    int hold;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk_i);
      end
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // effective geometry
  function automatic int eff_r();
    int r = int'(radius_reg);
    if (r < 1) r = 1;
    if (r > 4) r = 4;
    return r;
  endfunction

  function automatic int eff_dim(int v, int r);
    if (v < r + 1) v = r + 1;
    if (v < 2) v = 2;
    if (v > 1024) v = 1024;
    return v;
  endfunction

  function automatic int mirror(int i, int n);
    if (i < 0) i = -i;
    if (i > n - 1) i = 2 * (n - 1) - i;
    if (i < 0) i = 0;
    if (i > n - 1) i = n - 1;
    return i;
  endfunction

  function automatic logic [swmf_pkg::PIX_W-1:0] side_median(int y, int x, int r, int w,
                                                             int h, int s);
    int span [8][4] = '{'{-1, 0, -1, 1}, '{0, 1, -1, 1}, '{-1, 1, -1, 0},
                        '{-1, 1, 0, 1}, '{-1, 0, -1, 0}, '{-1, 0, 0, 1},
                        '{0, 1, -1, 0}, '{0, 1, 0, 1}};
    logic [7:0] v [3][45];
    logic [7:0] t;
    logic [swmf_pkg::PIX_W-1:0] p, res;
    int n, k, i, j, c, yy, xx;
    n = 0;
    res = '0;
    for (yy = y + span[s][2] * r; yy <= y + span[s][3] * r; yy++)
      for (xx = x + span[s][0] * r; xx <= x + span[s][1] * r; xx++) begin
        p = line_mem[mirror(yy, h) % STORE_ROWS][mirror(xx, w) % STORE_COLS];
        for (c = 0; c < 3; c++) v[c][n] = p[8*c +: 8];
        n++;
      end
    k = n / 2;
    if (k < 1) k = 1;
    for (c = 0; c < 3; c++) begin
      for (i = 1; i < n; i++) begin
        t = v[c][i];
        j = i - 1;
        while (j >= 0 && v[c][j] > t) begin
          v[c][j+1] = v[c][j];
          j--;
        end
        v[c][j+1] = t;
      end
      res[8*c +: 8] = v[c][k-1];
    end
    return res;
  endfunction

  function automatic void predict_output(int r, int w, int h, int unsigned total);
    filt_pix_t e;
    logic [swmf_pkg::PIX_W-1:0] src, cand;
    int y, x, s, c, err, best_err, a, b;
    y = pix_out_cnt / w;
    x = pix_out_cnt % w;
    src = line_mem[y % STORE_ROWS][x % STORE_COLS];
    best_err = 32'h7fffffff;
    e = '0;
    for (s = 0; s < swmf_pkg::NUM_SIDES; s++) begin
      cand = side_median(y, x, r, w, h, s);
      err = 0;
      for (c = 0; c < 3; c++) begin
        a = int'(src[8*c +: 8]);
        b = int'(cand[8*c +: 8]);
        err += (a > b) ? a - b : b - a;
      end
      if (err < best_err) begin
        best_err = err;
        e.bgr = cand;
        e.side = s[swmf_pkg::SIDE_W-1:0];
      end
    end
    e.last = (pix_out_cnt + 1 == total);
    pending_pix.push_back(e);
    pix_out_cnt++;
    if (pix_out_cnt >= total) begin
      pix_out_cnt = 0;
      pix_in_cnt = 0;
    end
  endfunction

  function automatic void predict_request(bit cmd, logic [swmf_pkg::PIX_W-1:0] px);
    int r, w, h, y, x;
    int unsigned total, lag;
    r = eff_r();
    w = eff_dim(int'(width_reg), r);
    h = eff_dim(int'(height_reg), r);
    total = w * h;
    lag = r * w + r;
    if (cmd == CMD_PIXEL && pix_in_cnt < total) begin
      y = pix_in_cnt / w;
      x = pix_in_cnt % w;
      line_mem[y % STORE_ROWS][x] = px;
      pix_in_cnt++;
      if (pix_in_cnt > pix_out_cnt + lag || pix_in_cnt == total)
        predict_output(r, w, h, total);
    end else if (pix_in_cnt >= total && pix_out_cnt < total) begin
      predict_output(r, w, h, total);
    end
  endfunction

  // output checker
  always @(posedge clk_i) begin
    filt_pix_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pix.size() == 0) begin
        $error("unexpected output request bgr=%h", out_bgr_o);
        n_errors++;
      end else begin
        e = pending_pix.pop_front();
        if (out_bgr_o !== e.bgr) begin
          $error("out_bgr expected %h actual %h", e.bgr, out_bgr_o);
          n_errors++;
        end
        if (chosen_side_o !== e.side) begin
          $error("chosen_side expected %0d actual %0d", e.side, chosen_side_o);
          n_errors++;
        end
        if (frame_last_o !== e.last) begin
          $error("frame_last expected %0d actual %0d", e.last, frame_last_o);
          n_errors++;
        end
      end
    end
  end

  task automatic send_req(bit cmd, logic [swmf_pkg::PIX_W-1:0] px);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    pixel_bgr_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(cmd, px);
    n_reqs++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(swmf_pkg::cfg_idx_e idx, int val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[swmf_pkg::CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      swmf_pkg::CFG_WIDTH: width_reg = val[swmf_pkg::CFG_W-1:0];
      swmf_pkg::CFG_HEIGHT: height_reg = val[swmf_pkg::CFG_W-1:0];
      default: radius_reg = val[swmf_pkg::RAD_W-1:0];
    endcase
    pix_in_cnt = 0;
    pix_out_cnt = 0;
  endtask

  task automatic set_geometry(int w, int h, int r);
    write_reg(swmf_pkg::CFG_RADIUS, r);
    write_reg(swmf_pkg::CFG_WIDTH, w);
    write_reg(swmf_pkg::CFG_HEIGHT, h);
  endtask

  function automatic logic [swmf_pkg::PIX_W-1:0] rand_pixel();
    logic [swmf_pkg::PIX_W-1:0] p;
    int c;
    case ($urandom_range(0, 3))
      0: for (c = 0; c < 3; c++) p[8*c +: 8] = 8'($urandom_range(0, 3));
      1: for (c = 0; c < 3; c++) p[8*c +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: p = swmf_pkg::PIX_W'($urandom);
    endcase
    return p;
  endfunction

  // drains until the frame in progress is fully flushed
  task automatic flush_frame();
    while (pix_in_cnt != 0) send_req(CMD_DRAIN, swmf_pkg::PIX_W'($urandom));
  endtask

  task automatic run_frame(int noise_pct);
    int total, i;
    total = eff_dim(int'(width_reg), eff_r()) * eff_dim(int'(height_reg), eff_r());
    for (i = 0; i < total; i++) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_req(CMD_DRAIN, swmf_pkg::PIX_W'($urandom));
      send_req(CMD_PIXEL, rand_pixel());
    end
    flush_frame();
  endtask

  task automatic test_small_frame();
    logic [swmf_pkg::PIX_W-1:0] px [12] = '{24'h000000, 24'hffffff, 24'haaaaaa,
                                            24'h555555, 24'h0000ff, 24'h00ff00,
                                            24'hff0000, 24'h010203, 24'hfefdfc,
                                            24'h808080, 24'h7f7f7f, 24'h123456};
    set_geometry(4, 3, 1);
    send_req(CMD_DRAIN, 24'hffffff);
    foreach (px[i]) send_req(CMD_PIXEL, px[i]);
    send_req(CMD_PIXEL, 24'hc0ffee);
    flush_frame();
  endtask

  task automatic test_clamped_regs();
    int i;
    set_geometry(0, 0, 0);
    run_frame(0);
    set_geometry(3, 5, 7);
    run_frame(10);
    write_reg(swmf_pkg::CFG_WIDTH, 2047);
    for (i = 0; i < 6; i++) send_req(CMD_PIXEL, rand_pixel());
    set_geometry(2, 2047, 1);
    for (i = 0; i < 20; i++) send_req(CMD_PIXEL, rand_pixel());
  endtask

  task automatic test_backpressure();
    set_geometry(8, 4, 1);
    hold_req = 1'b1;
    run_frame(0);
  endtask

  task automatic test_random_frames();
    int r, sel;
    while (n_reqs < TARGET_REQS) begin
      if (n_reqs > TARGET_REQS - 200) idle_en = 1'b0;
      sel = $urandom_range(0, 9);
      r = (sel < 6) ? 1 : (sel < 8) ? 2 : (sel < 9) ? 3 : 4;
      if (r == 4)
        set_geometry($urandom_range(5, 9), $urandom_range(5, 7), r);
      else
        set_geometry($urandom_range(r + 1, r + 12), $urandom_range(r + 1, r + 6), r);
      run_frame($urandom_range(0, 1) ? 0 : 15);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_small_frame();
    test_clamped_regs();
    test_backpressure();
    test_random_frames();
    settle();
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
